FILE: rtl/core/cartridge_address_mapper_assert.svh
// ----------------------------------------------------------------------------
// Cartridge address mapper assertion macros
// Concurrent check macros shared by the mapper RTL.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_ADDRESS_MAPPER_ASSERT_SVH
`define CARTRIDGE_ADDRESS_MAPPER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CAM_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define CAM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/cam_pkg.sv
// ----------------------------------------------------------------------------
// Cartridge address mapper package
// Word types, codes and control structs shared across the mapper.
// ----------------------------------------------------------------------------
package cam_pkg;

   // default memory sizes
   localparam int ROM_ADDR_BITS_DEF = 20;
   localparam int RAM_ADDR_BITS_DEF = 17;

   // width of the unmasked store indexes produced by the decoder
   localparam int ROM_IDX_BITS = 22;
   localparam int RAM_IDX_BITS = 19;

   localparam int CSR_DATA_BITS = 5;
   localparam int CSR_INDEX_BITS = 2;

   // request kinds
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_LOAD  = 2'd2;

   // result source codes
   localparam logic [1:0] SRC_ROM  = 2'd0;
   localparam logic [1:0] SRC_RAM  = 2'd1;
   localparam logic [1:0] SRC_OPEN = 2'd2;
   localparam logic [1:0] SRC_NONE = 2'd3;

   // mapping modes
   localparam logic [1:0] MODE_LOROM = 2'd1;
   localparam logic [1:0] MODE_HIROM = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAP_MODE      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROM_SIZE_LOG2 = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAM_ENABLE    = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAM_SIZE_LOG2 = 2'd3;

   // register reset values
   localparam logic [1:0] MAP_MODE_RST      = 2'd0;
   localparam logic [4:0] ROM_SIZE_LOG2_RST = 5'd15;
   localparam logic       RAM_ENABLE_RST    = 1'b0;
   localparam logic [4:0] RAM_SIZE_LOG2_RST = 5'd10;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  bank;
      logic [15:0] offset;
      logic [7:0]  write_data;
      logic [7:0]  open_bus;
      logic [19:0] load_address;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [1:0] source;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic clear_en;
      logic issue;
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
   } sts_type;

endpackage

FILE: rtl/core/cam_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write RAM
// One write port, one read port, registered read data held when not read.
// ----------------------------------------------------------------------------
module cam_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/cam_ctrl.sv
// ----------------------------------------------------------------------------
// Cartridge address mapper controller
// Sequences the RAM clearing pass, request issue and result hand-off.
// ----------------------------------------------------------------------------
module cam_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cam_pkg::cmd_type cmd,
   input  cam_pkg::sts_type sts
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // output register can take a word if empty or drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.issue = 1'b1;
               state_in  = ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/core/cam_datapath.sv
// ----------------------------------------------------------------------------
// Cartridge address mapper datapath
// Config registers, bank decode, ROM and RAM stores, result register.
// ----------------------------------------------------------------------------
module cam_datapath #(
   parameter int ROM_ADDR_BITS = cam_pkg::ROM_ADDR_BITS_DEF,
   parameter int RAM_ADDR_BITS = cam_pkg::RAM_ADDR_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [cam_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cam_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  cam_pkg::req_type                   req_word,
   output cam_pkg::rsp_type                   rsp_word,
   input  cam_pkg::cmd_type                   cmd,
   output cam_pkg::sts_type                   sts
);

   localparam logic [7:0] BANK_RAM_LO  = 8'h70;
   localparam logic [7:0] BANK_RAM_END = 8'h7E;
   localparam logic [7:0] BANK_RAM_TOP = 8'hF0;

   // config registers
   logic [1:0] map_mode_ff;
   logic [4:0] rom_size_log2_ff;
   logic       ram_enable_ff;
   logic [4:0] ram_size_log2_ff;

   // decode
   logic [6:0]                     bank_lo;
   logic                           ram_hit;
   logic                           rom_hit;
   logic [cam_pkg::RAM_IDX_BITS-1:0] ram_idx;
   logic [cam_pkg::ROM_IDX_BITS-1:0] rom_idx;
   logic [cam_pkg::ROM_IDX_BITS-1:0] load_idx;
   logic [RAM_ADDR_BITS-1:0]       ram_addr;
   logic [ROM_ADDR_BITS-1:0]       rom_rd_addr;
   logic [ROM_ADDR_BITS-1:0]       rom_wr_addr;
   logic                           is_read;

   // clearing pass
   logic [RAM_ADDR_BITS-1:0] clr_cnt_ff;

   // memory ports
   logic                     ram_we;
   logic [RAM_ADDR_BITS-1:0] ram_wr_addr;
   logic [7:0]               ram_wr_data;
   logic                     ram_re;
   logic [7:0]               ram_rd_data;
   logic                     rom_we;
   logic                     rom_re;
   logic [7:0]               rom_rd_data;

   // issued access and result
   logic [1:0]       src_ff;
   logic [7:0]       obus_ff;
   logic [1:0]       src_in;
   cam_pkg::rsp_type rsp_ff;
   cam_pkg::rsp_type rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_mode_ff      <= cam_pkg::MAP_MODE_RST;
         rom_size_log2_ff <= cam_pkg::ROM_SIZE_LOG2_RST;
         ram_enable_ff    <= cam_pkg::RAM_ENABLE_RST;
         ram_size_log2_ff <= cam_pkg::RAM_SIZE_LOG2_RST;
      end else if (csr_we) begin
         case (csr_index)
            cam_pkg::CSR_MAP_MODE:      map_mode_ff      <= csr_wdata[1:0];
            cam_pkg::CSR_ROM_SIZE_LOG2: rom_size_log2_ff <= csr_wdata;
            cam_pkg::CSR_RAM_ENABLE:    ram_enable_ff    <= csr_wdata[0];
            cam_pkg::CSR_RAM_SIZE_LOG2: ram_size_log2_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign bank_lo = req_word.bank[6:0];

   always_comb begin
      ram_hit = 1'b0;
      rom_hit = 1'b0;
      ram_idx = '0;
      rom_idx = '0;
      case (map_mode_ff)
         cam_pkg::MODE_LOROM: begin
            ram_hit = ((req_word.bank >= BANK_RAM_LO && req_word.bank < BANK_RAM_END)
                       || req_word.bank >= BANK_RAM_TOP)
                      && !req_word.offset[15] && ram_enable_ff;
            rom_hit = req_word.offset[15] || bank_lo[6];
            ram_idx = {req_word.bank[3:0], req_word.offset[14:0]};
            rom_idx = {bank_lo, req_word.offset[14:0]};
         end
         cam_pkg::MODE_HIROM: begin
            // window 0x6000-0x7FFF in the banks with bit 6 clear (0x00-0x3F, 0x80-0xBF)
            ram_hit = !bank_lo[6] && (req_word.offset[15:13] == 3'b011) && ram_enable_ff;
            rom_hit = req_word.offset[15] || bank_lo[6];
            ram_idx = {bank_lo[5:0], req_word.offset[12:0]};
            rom_idx = {bank_lo[5:0], req_word.offset};
         end
         default: ;
      endcase
   end

   // size masks: bit i survives when i < log2 size; saturates at the store size
   always_comb begin
      for (int i = 0; i < RAM_ADDR_BITS; i++) begin
         ram_addr[i] = ram_idx[i] && (ram_size_log2_ff > 5'(i));
      end
      for (int i = 0; i < ROM_ADDR_BITS; i++) begin
         rom_rd_addr[i] = rom_idx[i] && (rom_size_log2_ff > 5'(i));
      end
   end

   assign load_idx    = cam_pkg::ROM_IDX_BITS'(req_word.load_address);
   assign rom_wr_addr = load_idx[ROM_ADDR_BITS-1:0];

   assign is_read = (req_word.kind == cam_pkg::KIND_READ);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_en) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   assign sts.clear_last = &clr_cnt_ff;

   assign ram_we      = cmd.clear_en
                        || (cmd.issue && req_word.kind == cam_pkg::KIND_WRITE && ram_hit);
   assign ram_wr_addr = cmd.clear_en ? clr_cnt_ff : ram_addr;
   assign ram_wr_data = cmd.clear_en ? 8'h00 : req_word.write_data;
   assign ram_re      = cmd.issue && is_read && ram_hit;
   assign rom_we      = cmd.issue && req_word.kind == cam_pkg::KIND_LOAD;
   assign rom_re      = cmd.issue && is_read && !ram_hit && rom_hit;

   cam_ram #(
      .WIDTH (8),
      .DEPTH (1 << RAM_ADDR_BITS)
   ) u_ram_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_re),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   cam_ram #(
      .WIDTH (8),
      .DEPTH (1 << ROM_ADDR_BITS)
   ) u_rom_store (
      .clock   (clock),
      .wr_en   (rom_we),
      .wr_addr (rom_wr_addr),
      .wr_data (req_word.write_data),
      .rd_en   (rom_re),
      .rd_addr (rom_rd_addr),
      .rd_data (rom_rd_data)
   );

   always_comb begin
      if (!is_read) begin
         src_in = cam_pkg::SRC_NONE;
      end else if (ram_hit) begin
         src_in = cam_pkg::SRC_RAM;
      end else if (rom_hit) begin
         src_in = cam_pkg::SRC_ROM;
      end else begin
         src_in = cam_pkg::SRC_OPEN;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         src_ff  <= src_in;
         obus_ff <= req_word.open_bus;
      end
   end

   always_comb begin
      rsp_in.source = src_ff;
      case (src_ff)
         cam_pkg::SRC_ROM:  rsp_in.read_data = rom_rd_data;
         cam_pkg::SRC_RAM:  rsp_in.read_data = ram_rd_data;
         cam_pkg::SRC_OPEN: rsp_in.read_data = obus_ff;
         default:           rsp_in.read_data = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

FILE: rtl/core/cartridge_address_mapper.sv
// ----------------------------------------------------------------------------
// Cartridge address mapper
// Low-ROM / high-ROM bank decoder with ROM image store and battery RAM.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the battery RAM, one byte
// per cycle over all 2**RAM_ADDR_BITS entries, and holds req_stall high until
// it ends; register writes are taken during that time. Then each word is
// decoded and sent to the ROM or RAM store in the accept cycle, and the
// registered store read is loaded into the result register once that register
// is free. No new word is accepted until the last one has reached the result
// register, which lets the next word in while a result waits behind rsp_stall.
module cartridge_address_mapper #(
   parameter int ROM_ADDR_BITS = cam_pkg::ROM_ADDR_BITS_DEF,
   parameter int RAM_ADDR_BITS = cam_pkg::RAM_ADDR_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  cam_pkg::req_type                   req_word,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output cam_pkg::rsp_type                   rsp_word,
   input  logic                               csr_we,
   input  logic [cam_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cam_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   cam_pkg::cmd_type cmd;
   cam_pkg::sts_type sts;

   cam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   cam_datapath #(
      .ROM_ADDR_BITS (ROM_ADDR_BITS),
      .RAM_ADDR_BITS (RAM_ADDR_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_word  (req_word),
      .rsp_word  (rsp_word),
      .cmd       (cmd),
      .sts       (sts)
   );

`include "cartridge_address_mapper_assert.svh"

   // no word taken while the RAM is being cleared
   `CAM_ASSERT_IMPL(a_stall_in_clear, cmd.clear_en, req_stall, "word accepted during RAM clear")
   // one word in flight at a time
   `CAM_ASSERT_NEXT(a_single_issue, cmd.issue, !cmd.issue && req_stall, "back-to-back issue")
   // result register never overwritten while a result is stalled
   `CAM_ASSERT_IMPL(a_no_overwrite, cmd.rsp_load && rsp_valid, !rsp_stall, "result overwritten")
   // clearing pass ends after the last entry
   `CAM_ASSERT_NEXT(a_clear_ends, cmd.clear_en && sts.clear_last, !cmd.clear_en, "clear overran")

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Cartridge address mapper testbench
// Drives bus reads, bus writes and ROM image loads through the valid/stall
// request channel under several mapping and size settings. A scoreboard keeps
// its own ROM and battery RAM images, predicts every reply word and checks it
// in order. Both channels idle at random, and the reply side holds off once
// for a long stretch so that the block backs up into its request port.
// ----------------------------------------------------------------------------
module tb_top;
   import cam_pkg::*;

   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int ROM_WORDS = 1 << ROM_ADDR_BITS_DEF;
   localparam int RAM_WORDS = 1 << RAM_ADDR_BITS_DEF;
   // the watchdog limit also covers the RAM clearing pass after reset
   localparam int STALL_LIMIT = 400000;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 60;

   class mapper_scoreboard;
      logic [1:0] map_mode;
      logic [4:0] rom_lg;
      logic       ram_en;
      logic [4:0] ram_lg;
      logic [7:0] rom_img [0:ROM_WORDS-1];
      logic [7:0] ram_img [0:RAM_WORDS-1];
      rsp_type    due_rsp [$];
      int         errors;
      int         replies;

      function new();
         map_mode = MAP_MODE_RST;
         rom_lg = ROM_SIZE_LOG2_RST;
         ram_en = RAM_ENABLE_RST;
         ram_lg = RAM_SIZE_LOG2_RST;
         for (int i = 0; i < RAM_WORDS; i++) ram_img[i] = 8'h00;
         errors = 0;
         replies = 0;
      endfunction

      function void set_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_MAP_MODE:      map_mode = data[1:0];
            CSR_ROM_SIZE_LOG2: rom_lg = data;
            CSR_RAM_ENABLE:    ram_en = data[0];
            CSR_RAM_SIZE_LOG2: ram_lg = data;
            default: ;
         endcase
      endfunction

      function int unsigned rom_mask();
         int n;
         n = (rom_lg > ROM_ADDR_BITS_DEF) ? ROM_ADDR_BITS_DEF : int'(rom_lg);
         return (1 << n) - 1;
      endfunction

      function int unsigned ram_mask();
         int n;
         n = (ram_lg > RAM_ADDR_BITS_DEF) ? RAM_ADDR_BITS_DEF : int'(ram_lg);
         return (1 << n) - 1;
      endfunction

      // returns 1 on a RAM hit; otherwise rom_hit tells whether a read lands in ROM
      function bit map_access(input logic [7:0] bank, input logic [15:0] off,
                              output int unsigned idx, output bit rom_hit);
         logic [6:0] b;
         b = bank[6:0];
         rom_hit = 1'b0;
         idx = 0;
         if (map_mode == MODE_LOROM) begin
            if (((bank >= 8'h70 && bank < 8'h7e) || bank >= 8'hf0) &&
                off < 16'h8000 && ram_en) begin
               idx = {bank[3:0], off[14:0]};
               return 1'b1;
            end
            if (off >= 16'h8000 || b >= 7'h40) begin
               rom_hit = 1'b1;
               idx = {b, off[14:0]};
            end
         end else if (map_mode == MODE_HIROM) begin
            if (b < 7'h40 && off >= 16'h6000 && off <= 16'h7fff && ram_en) begin
               idx = {b[5:0], off[12:0]};
               return 1'b1;
            end
            if (off >= 16'h8000 || b >= 7'h40) begin
               rom_hit = 1'b1;
               idx = {b[5:0], off};
            end
         end
         return 1'b0;
      endfunction

      // masked ROM index a read of this address would fetch, if any
      function bit rom_target(input logic [7:0] bank, input logic [15:0] off,
                              output int unsigned ridx);
         bit ram_hit;
         bit rom_hit;
         ram_hit = map_access(bank, off, ridx, rom_hit);
         ridx = ridx & rom_mask();
         return !ram_hit && rom_hit;
      endfunction

      function void note_access(input req_type w);
         rsp_type     e;
         int unsigned idx;
         bit          rom_hit;
         e.read_data = 8'h00;
         e.source = SRC_NONE;
         case (w.kind)
            KIND_READ: begin
               if (map_access(w.bank, w.offset, idx, rom_hit)) begin
                  e.read_data = ram_img[idx & ram_mask()];
                  e.source = SRC_RAM;
               end else if (rom_hit) begin
                  e.read_data = rom_img[idx & rom_mask()];
                  e.source = SRC_ROM;
               end else begin
                  e.read_data = w.open_bus;
                  e.source = SRC_OPEN;
               end
            end
            KIND_WRITE: begin
               if (map_access(w.bank, w.offset, idx, rom_hit))
                  ram_img[idx & ram_mask()] = w.write_data;
            end
            KIND_LOAD: rom_img[w.load_address] = w.write_data;
            default: ;
         endcase
         due_rsp.push_back(e);
      endfunction

      task report(input string msg);
         $display("ERROR @%0t: %s", $time, msg);
         errors++;
      endtask

      task check_reply(input rsp_type got);
         rsp_type want;
         replies++;
         if (due_rsp.size() == 0) begin
            report($sformatf("reply word with nothing pending: data %h source %0d",
                             got.read_data, got.source));
            return;
         end
         want = due_rsp.pop_front();
         if (got.read_data !== want.read_data)
            report($sformatf("reply %0d read_data %h, want %h",
                             replies, got.read_data, want.read_data));
         if (got.source !== want.source)
            report($sformatf("reply %0d source %0d, want %0d",
                             replies, got.source, want.source));
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;
   logic    csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   mapper_scoreboard sb = new();
   bit          rom_loaded [0:ROM_WORDS-1];
   logic [23:0] hot_addr [$];
   bit          req_gaps = 1'b1;
   bit          rsp_gaps = 1'b1;
   bit          held = 1'b0;
   int          idle_cycles = 0;

   logic [4:0] set_mode   [PHASES] = '{MODE_HIROM, MODE_LOROM, MODE_LOROM, MODE_HIROM,
                                       MODE_SPARE, MODE_NONE, MODE_HIROM, MODE_LOROM};
   logic [4:0] set_rom_lg [PHASES] = '{20, 15, 17, 31, 15, 21, 16, 20};
   logic [4:0] set_ram_en [PHASES] = '{1, 1, 0, 1, 1, 1, 0, 1};
   logic [4:0] set_ram_lg [PHASES] = '{17, 10, 13, 31, 12, 18, 17, 11};

   always #5 clock = ~clock;

   cartridge_address_mapper uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_access(req_word);
         if (rsp_valid && !rsp_stall) sb.check_reply(rsp_word);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // reply side: random stall bursts plus one long hold-off
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (!held && sb.replies >= 200) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (90) @(posedge clock);
         end else if (rsp_gaps && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   task automatic push_word(input req_type w);
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // sends one access; a read of a ROM byte not yet loaded gets a load first
   task automatic issue(input logic [1:0] kind, input logic [7:0] bank,
                        input logic [15:0] off, input logic [19:0] laddr);
      req_type     w;
      req_type     pre;
      int unsigned ridx;
      bit          hit;
      w.kind = kind;
      w.bank = bank;
      w.offset = off;
      w.write_data = 8'($urandom);
      w.open_bus = 8'($urandom);
      w.load_address = laddr;
      hit = sb.rom_target(bank, off, ridx);
      if (kind == KIND_READ && hit && !rom_loaded[ridx]) begin
         pre = w;
         pre.kind = KIND_LOAD;
         pre.write_data = 8'($urandom);
         pre.load_address = ridx[19:0];
         rom_loaded[ridx] = 1'b1;
         push_word(pre);
      end
      if (kind == KIND_LOAD) rom_loaded[laddr] = 1'b1;
      push_word(w);
   endtask

   task automatic rd(input logic [7:0] bank, input logic [15:0] off);
      issue(KIND_READ, bank, off, 20'($urandom));
   endtask

   task automatic wr(input logic [7:0] bank, input logic [15:0] off);
      issue(KIND_WRITE, bank, off, 20'($urandom));
   endtask

   task automatic random_item();
      logic [1:0]  kind;
      logic [7:0]  bank;
      logic [15:0] off;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) kind = KIND_READ;
      else if (pick < 75) kind = KIND_WRITE;
      else if (pick < 95) kind = KIND_LOAD;
      else kind = KIND_SPARE;
      pick = $urandom_range(0, 99);
      if (pick < 40 && hot_addr.size() > 0) begin
         {bank, off} = hot_addr[$urandom_range(0, hot_addr.size() - 1)];
      end else if (pick < 70 && sb.map_mode == MODE_LOROM) begin
         bank = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'h70, 8'h7d))
                                            : 8'($urandom_range(8'hf0, 8'hff));
         off = 16'($urandom_range(0, 16'h7fff));
      end else if (pick < 70 && sb.map_mode == MODE_HIROM) begin
         bank = {1'($urandom), 1'b0, 6'($urandom)};
         off = 16'($urandom_range(16'h6000, 16'h7fff));
      end else begin
         bank = 8'($urandom);
         off = 16'($urandom);
      end
      hot_addr.push_back({bank, off});
      if (hot_addr.size() > 24) void'(hot_addr.pop_front());
      issue(kind, bank, off, 20'($urandom));
   endtask

   // drain before touching registers; the extra edge lets the monitor log
   // a word accepted at the edge the last push returned on
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.due_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_INDEX_BITS-1:0] idx,
                          input logic [CSR_DATA_BITS-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   task automatic apply_setting(input logic [4:0] mode, input logic [4:0] rom_lg,
                                input logic [4:0] ram_en, input logic [4:0] ram_lg);
      csr_put(CSR_MAP_MODE, mode);
      csr_put(CSR_ROM_SIZE_LOG2, rom_lg);
      csr_put(CSR_RAM_ENABLE, ram_en);
      csr_put(CSR_RAM_SIZE_LOG2, ram_lg);
      csr_we <= 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: no cartridge, everything open bus
      rd(8'h00, 16'h0000);
      rd(8'hff, 16'hffff);
      wr(8'h70, 16'h0000);
      issue(KIND_LOAD, 8'h00, 16'h0000, 20'h00000);
      issue(KIND_LOAD, 8'hff, 16'hffff, 20'hfffff);
      issue(KIND_SPARE, 8'h80, 16'h8000, 20'h55555);

      settle();
      apply_setting(MODE_LOROM, 5'd15, 5'd1, 5'd10);
      wr(8'h7d, 16'h7fff);
      rd(8'h7d, 16'h7fff);
      wr(8'hf0, 16'h0000);    // bank 0xf0 itself is RAM
      rd(8'hf0, 16'h0000);
      rd(8'h70, 16'h0000);
      rd(8'h7e, 16'h0000);
      rd(8'hef, 16'h0000);
      rd(8'h3f, 16'h7fff);
      rd(8'h40, 16'h0000);
      rd(8'h00, 16'h8000);
      rd(8'hff, 16'hffff);
      wr(8'h00, 16'h8000);

      settle();
      apply_setting(MODE_HIROM, 5'd20, 5'd1, 5'd17);
      wr(8'h00, 16'h6000);
      rd(8'h00, 16'h6000);
      wr(8'hbf, 16'h7fff);
      rd(8'h3f, 16'h7fff);
      rd(8'h40, 16'h6000);
      rd(8'h00, 16'h5fff);
      rd(8'hc0, 16'h0000);
      rd(8'hff, 16'hffff);

      for (int p = 0; p < PHASES; p++) begin
         settle();
         apply_setting(set_mode[p], set_rom_lg[p], set_ram_en[p], set_ram_lg[p]);
         hot_addr.delete();
         req_gaps = (p < PHASES - 1) && ($urandom_range(0, 2) != 0);
         rsp_gaps = (p < PHASES - 1) && ($urandom_range(0, 2) != 0);
         repeat (PHASE_ITEMS) random_item();
      end

      settle();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.due_rsp.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/cam_pkg.sv
rtl/core/cam_ram.sv
rtl/core/cam_ctrl.sv
rtl/core/cam_datapath.sv
rtl/core/cartridge_address_mapper.sv
verif/tb_top.sv
